FILE: design/slfp_pkg.sv
// ----------------------------------------------------------------------------
// slfp_pkg
// shared types and constants of the sync/length frame parser
// ----------------------------------------------------------------------------
package slfp_pkg;

    // largest payload the frame format allows
    localparam logic [12:0] MAX_PAYLOAD = 13'd4096;

    // reset values of the configuration registers
    localparam logic [7:0]  SYNC_RESET    = 8'h55;
    localparam logic [12:0] MAXLEN_RESET  = 13'd4096;

    // register index, taken from paddr bit 2
    localparam logic REG_SYNC   = 1'b0;
    localparam logic REG_MAXLEN = 1'b1;

    // configuration as seen by the parser
    typedef struct packed {
        logic [7:0]  sync_byte;
        logic [12:0] max_length;
    } t_cfg;

    // one result word
    typedef struct packed {
        logic [15:0] command;
        logic [12:0] frame_length;
        logic [11:0] offset;
        logic [7:0]  payload_byte;
        logic        has_data;
        logic        last;
    } t_result;

endpackage

FILE: design/slfp_regs.sv
// ----------------------------------------------------------------------------
// slfp_regs
// apb configuration registers: sync byte and maximum payload length
// ----------------------------------------------------------------------------
module slfp_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output slfp_pkg::t_cfg       o_cfg
);
    import slfp_pkg::*;

    logic [7:0]  r_sync_byte;
    logic [12:0] r_max_length;
    logic        wr_en;

    // write strobe in the access phase
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte  <= SYNC_RESET;
            r_max_length <= MAXLEN_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_SYNC:   r_sync_byte  <= pwdata[7:0];
                REG_MAXLEN: r_max_length <= pwdata[12:0];
                default:    ;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        unique case (paddr[2])
            REG_SYNC:   prdata = {24'd0, r_sync_byte};
            REG_MAXLEN: prdata = {19'd0, r_max_length};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg.sync_byte  = r_sync_byte;
    assign o_cfg.max_length = r_max_length;

endmodule

FILE: design/slfp_parser.sv
// ----------------------------------------------------------------------------
// slfp_parser
// header state machine and payload counter; one byte per step
// ----------------------------------------------------------------------------
module slfp_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  slfp_pkg::t_cfg       i_cfg,
    output logic                 o_res_valid,
    output slfp_pkg::t_result    o_res
);
    import slfp_pkg::*;

    typedef enum logic [2:0] {
        ST_HUNT1,
        ST_HUNT2,
        ST_CMD_HI,
        ST_CMD_LO,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_PAYLOAD
    } t_state;

    t_state      r_state,   n_state;
    logic [15:0] r_command, n_command;
    logic [15:0] r_length,  n_length;
    logic [12:0] r_count,   n_count;

    logic [12:0] limit;
    logic [15:0] len_full;
    logic [12:0] count_inc;

    // effective length limit and assembled length
    assign limit     = (i_cfg.max_length < MAX_PAYLOAD) ? i_cfg.max_length : MAX_PAYLOAD;
    assign len_full  = {r_length[15:8], i_byte};
    assign count_inc = r_count + 13'd1;

    // next state and result
    always_comb begin
        n_state     = r_state;
        n_command   = r_command;
        n_length    = r_length;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_res.command      = r_command;
        o_res.frame_length = r_length[12:0];
        o_res.offset       = 12'd0;
        o_res.payload_byte = 8'd0;
        o_res.has_data     = 1'b0;
        o_res.last         = 1'b1;
        unique case (r_state)
            ST_HUNT1: begin
                if (i_byte == i_cfg.sync_byte) n_state = ST_HUNT2;
            end
            ST_HUNT2: begin
                if (i_byte == i_cfg.sync_byte) begin
                    n_state = ST_CMD_HI;
                    n_count = 13'd0;
                end else begin
                    n_state = ST_HUNT1;
                end
            end
            ST_CMD_HI: begin
                n_command = {i_byte, 8'd0};
                n_state   = ST_CMD_LO;
            end
            ST_CMD_LO: begin
                n_command = {r_command[15:8], i_byte};
                n_state   = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                n_length = {i_byte, 8'd0};
                n_state  = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                // oversize frames are dropped without a result
                if (len_full > {3'd0, limit}) begin
                    n_state   = ST_HUNT1;
                    n_command = 16'd0;
                    n_length  = 16'd0;
                    n_count   = 13'd0;
                end else begin
                    n_length = len_full;
                    n_state  = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                o_res_valid = 1'b1;
                if (r_length != 16'd0) begin
                    o_res.offset       = r_count[11:0];
                    o_res.payload_byte = i_byte;
                    o_res.has_data     = 1'b1;
                    o_res.last         = ({3'd0, count_inc} == r_length);
                    n_count            = count_inc;
                end
                // empty frame or final byte closes the frame
                if (o_res.last) begin
                    n_state   = ST_HUNT1;
                    n_command = 16'd0;
                    n_length  = 16'd0;
                    n_count   = 13'd0;
                end
            end
            default: begin
                n_state = ST_HUNT1;
            end
        endcase
    end

    // state and frame registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_HUNT1;
            r_command <= 16'd0;
            r_length  <= 16'd0;
            r_count   <= 13'd0;
        end else if (i_step) begin
            r_state   <= n_state;
            r_command <= n_command;
            r_length  <= n_length;
            r_count   <= n_count;
        end
    end

endmodule

FILE: design/sync_length_frame_parser.sv
// ----------------------------------------------------------------------------
// sync_length_frame_parser
// deframer for sync-headed, length-prefixed byte frames
// ----------------------------------------------------------------------------
// input channel (i_valid/o_ready) carries one received byte per word.
// the parser hunts for two sync bytes, reads a big-endian command and a
// big-endian length, then emits one output word per payload byte with the
// command, length, offset and a last flag. an empty frame consumes one
// more byte and emits a single marker word with has_data low.
// oversize frames are dropped without any output word.
// a byte taken into the input register is parsed by the combinational parse
// logic, and its output word is registered in the output register once that
// register is free. throughput: one byte per cycle while the output register
// is free, set by the input register feeding the combinational parse logic
// and the output register.
// when the receiver holds i_ready low the output register keeps its word;
// while both registers hold a word o_ready falls in the same cycle, and an
// empty input register still takes one byte before o_ready falls.
// reset (synchronous, i_rst_n low) empties both registers, returns the
// parser to hunting and loads sync byte 0x55 and max length 4096.
// configuration is by apb: sync byte at 0x0, max length at 0x4.
// ----------------------------------------------------------------------------
module sync_length_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    // output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_command,
    output logic [12:0] o_frame_length,
    output logic [11:0] o_offset,
    output logic [7:0]  o_payload_byte,
    output logic        o_has_data,
    output logic        o_last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import slfp_pkg::*;

    t_cfg        cfg;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out;
    logic        out_free;
    logic        advance;
    logic        res_valid;
    t_result     res;

    // configuration registers
    slfp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // pipeline control
    assign out_free = ~r_out_valid | i_ready;
    assign advance  = r_in_valid & out_free;
    assign o_ready  = ~r_in_valid | advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready & i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // parse logic
    slfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance & res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance & res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_command      = r_out.command;
    assign o_frame_length = r_out.frame_length;
    assign o_offset       = r_out.offset;
    assign o_payload_byte = r_out.payload_byte;
    assign o_has_data     = r_out.has_data;
    assign o_last         = r_out.last;

endmodule

FILE: tb/tb_sync_length_frame_parser.sv
// ----------------------------------------------------------------------------
// tb_sync_length_frame_parser
// self-checking bench for the sync/length frame parser
// ----------------------------------------------------------------------------
// received bytes go in over the valid/ready input channel. an in-bench frame
// predictor follows the parser state and stores the output words each byte
// should cause in a small ring. a monitor takes the oldest one on every
// accepted output word and compares it field by field. the stimulus covers
// directed header corner cases, register extremes over apb, a frame at a
// reduced length limit and random frame streams under three idling mixes on
// the two channels.
// ----------------------------------------------------------------------------
module tb_sync_length_frame_parser;
    import slfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PEND_DEPTH     = 64;

    // parser phases as the predictor tracks them
    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        CMD_HI,
        CMD_LO,
        LEN_HI,
        LEN_LO,
        PAYLOAD
    } t_phase;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte      = 8'h00;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [15:0] o_command;
    logic [12:0] o_frame_length;
    logic [11:0] o_offset;
    logic [7:0]  o_payload_byte;
    logic        o_has_data;
    logic        o_last;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = 3'b000;
    logic [31:0] pwdata         = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state and register copy
    t_cfg        cfg_model;
    t_phase      frame_phase;
    logic [15:0] cmd_acc;
    logic [15:0] len_acc;
    logic [12:0] bytes_seen;
    t_result     pending_words [PEND_DEPTH];
    logic [5:0]  pend_wr = 6'd0;
    logic [5:0]  pend_rd = 6'd0;

    int errors        = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int quiet_cycles  = 0;
    int rx_bytes_sent = 0;

    sync_length_frame_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_command      (o_command),
        .o_frame_length (o_frame_length),
        .o_offset       (o_offset),
        .o_payload_byte (o_payload_byte),
        .o_has_data     (o_has_data),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver stalls
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // length limit in force
    function automatic logic [12:0] length_limit();
        if (cfg_model.max_length > MAX_PAYLOAD)
            return MAX_PAYLOAD;
        return cfg_model.max_length;
    endfunction

    function automatic void clear_frame_state();
        frame_phase = HUNT_FIRST;
        cmd_acc     = 16'h0;
        len_acc     = 16'h0;
        bytes_seen  = 13'h0;
    endfunction

    // advance the frame predictor by one received byte
    function automatic void take_rx_byte(input logic [7:0] b);
        t_result w;
        w = '0;
        case (frame_phase)
            HUNT_FIRST: begin
                if (b == cfg_model.sync_byte)
                    frame_phase = HUNT_SECOND;
            end
            HUNT_SECOND: begin
                if (b == cfg_model.sync_byte) begin
                    frame_phase = CMD_HI;
                    bytes_seen  = 13'h0;
                end else begin
                    frame_phase = HUNT_FIRST;
                end
            end
            CMD_HI: begin
                cmd_acc     = {b, 8'h00};
                frame_phase = CMD_LO;
            end
            CMD_LO: begin
                cmd_acc     = {cmd_acc[15:8], b};
                frame_phase = LEN_HI;
            end
            LEN_HI: begin
                len_acc     = {b, 8'h00};
                frame_phase = LEN_LO;
            end
            LEN_LO: begin
                len_acc = {len_acc[15:8], b};
                if (len_acc > length_limit())
                    clear_frame_state();
                else
                    frame_phase = PAYLOAD;
            end
            PAYLOAD: begin
                w.command      = cmd_acc;
                w.frame_length = len_acc[12:0];
                if (len_acc == 16'h0) begin
                    // empty frame: the byte is swallowed, a marker goes out
                    w.last = 1'b1;
                    clear_frame_state();
                end else begin
                    w.offset       = bytes_seen[11:0];
                    w.payload_byte = b;
                    w.has_data     = 1'b1;
                    bytes_seen     = bytes_seen + 13'd1;
                    w.last         = ({3'b000, bytes_seen} == len_acc);
                    if (w.last)
                        clear_frame_state();
                end
                pending_words[pend_wr] = w;
                pend_wr = pend_wr + 6'd1;
            end
            default: begin
                frame_phase = HUNT_FIRST;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // monitor: output check, input prediction and watchdog
    always @(posedge i_clk) begin : word_monitor
        t_result want_word;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pend_wr == pend_rd) begin
                    $error("output word with none pending: command %0h offset %0d",
                           o_command, o_offset);
                    errors++;
                end else begin
                    want_word = pending_words[pend_rd];
                    pend_rd   = pend_rd + 6'd1;
                    check_field("command", want_word.command, o_command);
                    check_field("frame_length", {3'b000, want_word.frame_length},
                                {3'b000, o_frame_length});
                    check_field("offset", {4'h0, want_word.offset}, {4'h0, o_offset});
                    check_field("payload_byte", {8'h00, want_word.payload_byte},
                                {8'h00, o_payload_byte});
                    check_field("has_data", {15'h0, want_word.has_data},
                                {15'h0, o_has_data});
                    check_field("last", {15'h0, want_word.last}, {15'h0, o_last});
                end
            end
            if (i_valid && o_ready)
                take_rx_byte(i_rx_byte);
        end
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sync_length_frame_parser: mismatch");
            $finish;
        end
    end

    // send one received byte, with random gaps ahead of it
    task automatic send_rx_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid   <= 1'b0;
            i_rx_byte <= 8'($urandom);
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        rx_bytes_sent++;
    endtask

    // stop sending and let every pending word and the pipeline drain
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pend_wr != pend_rd)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write then read back
    task automatic set_register(input logic idx, input logic [31:0] data);
        logic [31:0] want_rd;
        wait_idle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_SYNC)
            cfg_model.sync_byte = data[7:0];
        else
            cfg_model.max_length = data[12:0];
        // read phase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        want_rd = (idx == REG_SYNC) ? {24'h0, cfg_model.sync_byte}
                                    : {19'h0, cfg_model.max_length};
        if (prdata !== want_rd) begin
            $error("prdata: expected %0d, got %0d", want_rd, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // header, then as many payload bytes as the parser will take
    task automatic send_frame(input logic [15:0] cmd, input logic [15:0] len);
        int n_payload;
        n_payload = (len > length_limit()) ? 0 : ((len == 16'h0) ? 1 : int'(len));
        send_rx_byte(cfg_model.sync_byte);
        send_rx_byte(cfg_model.sync_byte);
        send_rx_byte(cmd[15:8]);
        send_rx_byte(cmd[7:0]);
        send_rx_byte(len[15:8]);
        send_rx_byte(len[7:0]);
        repeat (n_payload) send_rx_byte(8'($urandom));
    endtask

    // a byte that can never be taken as sync
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == cfg_model.sync_byte)
            b = b ^ 8'h01;
        return b;
    endfunction

    // header corner cases under reset settings
    task automatic test_directed();
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        // second byte not sync drops back to hunting
        send_rx_byte(SYNC_RESET);
        send_rx_byte(8'hAA);
        // empty frame marker
        send_frame(16'hFFFF, 16'd0);
        // single byte frame
        send_frame(16'h0000, 16'd1);
        // one over the limit is dropped silently
        send_frame(16'h1234, 16'd4097);
    endtask

    // register extremes and a sync change between the two sync bytes
    task automatic test_register_extremes();
        set_register(REG_SYNC, 32'h00);
        set_register(REG_MAXLEN, 32'd0);
        send_frame(16'($urandom), 16'd0);
        send_frame(16'($urandom), 16'd1);
        set_register(REG_SYNC, 32'hFF);
        set_register(REG_MAXLEN, 32'd1);
        send_frame(16'($urandom), 16'd1);
        send_frame(16'($urandom), 16'd2);
        set_register(REG_MAXLEN, 32'd4096);
        send_frame(16'($urandom), 16'hFFFF);
        send_frame(16'($urandom), 16'd3);
        // new sync value takes effect for the second sync byte
        send_rx_byte(cfg_model.sync_byte);
        set_register(REG_SYNC, 32'h3C);
        send_rx_byte(8'h3C);
        send_rx_byte(8'hA5);
        send_rx_byte(8'h5A);
        send_rx_byte(8'h00);
        send_rx_byte(8'h02);
        send_rx_byte(8'($urandom));
        send_rx_byte(8'($urandom));
        set_register(REG_SYNC, {24'h0, SYNC_RESET});
    endtask

    // frame exactly at a reduced limit, then one byte over it
    task automatic test_frame_at_limit();
        set_register(REG_MAXLEN, 32'd48);
        send_frame(16'($urandom), 16'd48);
        send_frame(16'($urandom), 16'd49);
        set_register(REG_MAXLEN, {19'h0, MAXLEN_RESET});
    endtask

    // random frame stream: mostly well-formed, some noise and broken frames
    task automatic test_random_frames(input int n_bytes, input int tx_pct, input int rx_pct);
        int unsigned pick;
        int          stop_at;
        logic [15:0] len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at     = rx_bytes_sent + n_bytes;
        while (rx_bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                set_register(REG_SYNC, $urandom_range(0, 255));
                case ($urandom_range(0, 2))
                    0:       set_register(REG_MAXLEN, $urandom_range(0, 32));
                    1:       set_register(REG_MAXLEN, $urandom_range(0, 4096));
                    default: set_register(REG_MAXLEN, {19'h0, MAX_PAYLOAD});
                endcase
            end else if (pick < 78) begin
                len = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 12))
                                                   : 16'($urandom_range(13, 64));
                if (len > length_limit())
                    len = {3'b000, length_limit()};
                send_frame(16'($urandom), len);
            end else if (pick < 88) begin
                len = 16'($urandom_range(int'(length_limit()) + 1, 65535));
                send_frame(16'($urandom), len);
            end else if (pick < 94) begin
                send_rx_byte(cfg_model.sync_byte);
                send_rx_byte(noise_byte());
            end else begin
                repeat ($urandom_range(1, 4)) send_rx_byte(noise_byte());
            end
        end
    endtask

    initial begin
        cfg_model.sync_byte  = SYNC_RESET;
        cfg_model.max_length = MAXLEN_RESET;
        clear_frame_state();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_register_extremes();
        test_frame_at_limit();
        test_random_frames(200, 33, 59);
        test_random_frames(200, 59, 33);
        test_random_frames(200, 0, 0);

        wait_idle();
        if (errors == 0)
            $display("sync_length_frame_parser: match");
        else
            $display("sync_length_frame_parser: mismatch");
        $finish;
    end

endmodule
